/* src/sefr_pkg.sv */
// Package for the STX/ETX frame receiver: byte codes, status codes,
// CRC-8 byte step and ASCII hex decode. No dependencies.
`default_nettype none

package sefr_pkg;

  localparam logic [7:0] BYTE_STX   = 8'h02;
  localparam logic [7:0] BYTE_ETX   = 8'h03;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CRC_POLY   = 8'hB1;
  localparam logic [7:0] CRC_INIT   = 8'h00;
  localparam logic [7:0] CRC_XOROUT = 8'hFF;

  typedef enum logic [2:0] {
    ST_GOOD_D     = 3'd0,
    ST_GOOD_A     = 3'd1,
    ST_GOOD_OTHER = 3'd2,
    ST_CRC_BAD    = 3'd3,
    ST_HEX_BAD    = 3'd4,
    ST_OVERFLOW   = 3'd5
  } status_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // one byte through the CRC-8 register, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok    = 1'b0;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok    = 1'b1;
      h.value = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      h.ok    = 1'b1;
      h.value = b[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* src/stx_etx_frame_receiver_crc8.sv */
// STX/ETX frame receiver with CRC-8 check, top level.
// Depends on sefr_pkg.
//
//  port group  dir  tdata          tuser                          tlast
//  s_axis      in   rx_byte[7:0]   -                              -
//  m_axis      out  data_byte[7:0] byte_valid, frame_status[2:0]  frame_done
//
// One beat per cycle sustained while the output beat is taken; decode and CRC
// step sit between the frame state registers and the output register.
// Reset returns to hunting for STX with the output register empty.
// s_axis_tready_o is high while the output register is empty or being taken;
// a stalled output holds its beat and blocks input until it is taken.
`default_nettype none

module stx_etx_frame_receiver_crc8 #(
  parameter int MAX_FRAME = 512
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] data_byte
  output logic [3:0]      m_axis_tuser_o,   // [0] byte_valid, [3:1] frame_status
  output logic            m_axis_tlast_o    // frame_done
);

  localparam int CW = $clog2(MAX_FRAME);
  localparam logic [CW-1:0] CNT_LIMIT = CW'(MAX_FRAME - 1);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HEX_HI  = 2'd2,
    PH_HEX_LO  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_D     = 2'd1,
    KIND_A     = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  phase_e           phase_q, phase_d;
  kind_e            kind_q, kind_d;
  logic [7:0]       crc_q, crc_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [3:0]       hi_q, hi_d;
  logic             hex_err_q, hex_err_d;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_data_q, out_data_d;
  logic             out_bv_q, out_bv_d;
  logic             out_done_q, out_done_d;
  sefr_pkg::status_e out_status_q, out_status_d;

  logic             in_beat;
  logic             out_beat;
  logic             emit;
  sefr_pkg::hex_t   hex;
  logic [7:0]       b;

  assign b               = s_axis_tdata_i;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat        = out_valid_q && m_axis_tready_i;
  assign hex             = sefr_pkg::hex_decode(b);

  always_comb begin
    phase_d      = phase_q;
    kind_d       = kind_q;
    crc_d        = crc_q;
    cnt_d        = cnt_q;
    hi_d         = hi_q;
    hex_err_d    = hex_err_q;
    emit         = 1'b0;
    out_data_d   = 8'd0;
    out_bv_d     = 1'b0;
    out_done_d   = 1'b0;
    out_status_d = sefr_pkg::ST_GOOD_D;
    if (in_beat) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (b == sefr_pkg::BYTE_STX) begin
            phase_d   = PH_PAYLOAD;
            crc_d     = sefr_pkg::CRC_INIT;
            cnt_d     = '0;
            kind_d    = KIND_EMPTY;
            hi_d      = 4'd0;
            hex_err_d = 1'b0;
          end
        end
        PH_PAYLOAD: begin
          if (b == sefr_pkg::BYTE_ETX) begin
            phase_d = PH_HEX_HI;
          end else if (cnt_q >= CNT_LIMIT) begin
            phase_d      = PH_HUNT;
            emit         = 1'b1;
            out_done_d   = 1'b1;
            out_status_d = sefr_pkg::ST_OVERFLOW;
          end else begin
            if (cnt_q == '0) begin
              kind_d = (b == sefr_pkg::CHAR_D) ? KIND_D :
                       (b == sefr_pkg::CHAR_A) ? KIND_A : KIND_OTHER;
            end
            crc_d      = sefr_pkg::crc8_byte(crc_q, b);
            cnt_d      = cnt_q + 1'b1;
            emit       = 1'b1;
            out_data_d = b;
            out_bv_d   = 1'b1;
          end
        end
        PH_HEX_HI: begin
          hex_err_d = !hex.ok;
          hi_d      = hex.value;
          phase_d   = PH_HEX_LO;
        end
        PH_HEX_LO: begin
          emit       = 1'b1;
          out_done_d = 1'b1;
          phase_d    = PH_HUNT;
          priority if (hex_err_q || !hex.ok) begin
            out_status_d = sefr_pkg::ST_HEX_BAD;
          end else if ({hi_q, hex.value} != (crc_q ^ sefr_pkg::CRC_XOROUT)) begin
            out_status_d = sefr_pkg::ST_CRC_BAD;
          end else if (kind_q == KIND_D) begin
            out_status_d = sefr_pkg::ST_GOOD_D;
          end else if (kind_q == KIND_A) begin
            out_status_d = sefr_pkg::ST_GOOD_A;
          end else begin
            out_status_d = sefr_pkg::ST_GOOD_OTHER;
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
    out_valid_d = emit || (out_valid_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      kind_q       <= KIND_EMPTY;
      crc_q        <= sefr_pkg::CRC_INIT;
      cnt_q        <= '0;
      hi_q         <= 4'd0;
      hex_err_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= 8'd0;
      out_bv_q     <= 1'b0;
      out_done_q   <= 1'b0;
      out_status_q <= sefr_pkg::ST_GOOD_D;
    end else begin
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      crc_q       <= crc_d;
      cnt_q       <= cnt_d;
      hi_q        <= hi_d;
      hex_err_q   <= hex_err_d;
      out_valid_q <= out_valid_d;
      if (emit) begin
        out_data_q   <= out_data_d;
        out_bv_q     <= out_bv_d;
        out_done_q   <= out_done_d;
        out_status_q <= out_status_d;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = {out_status_q, out_bv_q};
  assign m_axis_tlast_o  = out_done_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_LIMIT)
    else $error("payload count past frame limit");

  a_done_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o != m_axis_tuser_o[0]))
    else $error("beat must carry either a payload byte or a frame end");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o[3:1] <= sefr_pkg::ST_OVERFLOW)
    else $error("frame status out of range");

  a_stx_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && phase_q == PH_HUNT && b == sefr_pkg::BYTE_STX |=>
      phase_q == PH_PAYLOAD && cnt_q == '0)
    else $error("STX did not open a frame");

  a_hunt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && phase_q == PH_HUNT |-> !emit)
    else $error("beat emitted while hunting");

endmodule

`default_nettype wire
